// ----- src/vic_pkg.sv -----
package vic_pkg;

    localparam int LINE_BITS = 18;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_WINDOW = 2'd2;

    localparam logic [9:0] OFF_RESET_STATUS = 10'h000;
    localparam logic [9:0] OFF_WDOG_VECTOR  = 10'h002;
    localparam logic [9:0] OFF_PIN_ASSIGN   = 10'h004;
    localparam logic [9:0] OFF_PENDING      = 10'h040;
    localparam logic [9:0] OFF_WDOG_SERVICE = 10'h041;
    localparam logic [9:0] OFF_MASK         = 10'h044;
    localparam logic [9:0] OFF_AUTOVEC_EN   = 10'h04B;
    localparam logic [9:0] OFF_CTRL_BASE    = 10'h04C;
    localparam logic [9:0] OFF_SERIAL0_VEC  = 10'h1F0;
    localparam logic [9:0] OFF_SERIAL1_VEC  = 10'h230;
    localparam logic [9:0] OFF_PORT0_A      = 10'h1F8;
    localparam logic [9:0] OFF_PORT0_B      = 10'h1FC;
    localparam logic [9:0] OFF_PORT1_A      = 10'h238;
    localparam logic [9:0] OFF_PORT1_B      = 10'h23C;

    localparam logic [7:0]           RESET_STATUS_INIT = 8'h80;
    localparam logic [7:0]           WDOG_VECTOR_INIT  = 8'h0F;
    localparam logic [LINE_BITS-1:0] MASK_INIT         = 18'h3FFFE;

    localparam logic [7:0] AUTOVECTOR_BASE = 8'd24;
    localparam logic [7:0] FALLBACK_VECTOR = 8'h0F;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  offset;
        logic [31:0] write_data;
        logic [4:0]  irq_line;
        logic        irq_active;
    } vic_item_t;

    typedef struct packed {
        logic [7:0]           reset_status;
        logic [7:0]           watchdog_vector;
        logic [15:0]          pin_assignment;
        logic [LINE_BITS-1:0] mask_bits;
        logic [LINE_BITS-1:0] pending_bits;
        logic [7:0]           autovector_enables;
        logic [1:0][7:0]      serial_vectors;
    } vic_state_t;

    // key is level, priority, external flag; linen is the inverted line number
    typedef struct packed {
        logic [5:0] key;
        logic [4:0] linen;
        logic [7:0] vector;
    } vic_node_t;

    function automatic logic in_window(input logic [9:0] off);
        return (off >= 10'h140 && off < 10'h160) || (off >= 10'h180 && off < 10'h1A0) ||
               (off >= 10'h1C0 && off < 10'h1E0) || (off >= 10'h200 && off < 10'h220);
    endfunction

endpackage

// ----- src/vic_regs.sv -----
module vic_regs #(
    parameter int INTERNAL_SOURCES = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  vic_pkg::vic_item_t                item,
    output vic_pkg::vic_state_t               state_next,
    output logic [INTERNAL_SOURCES-1:0][7:0]  ctrl_next,
    output logic [31:0]                       read_data,
    output logic [1:0]                        status
);

    localparam logic [4:0] LAST_LINE = 5'(7 + INTERNAL_SOURCES);

    vic_pkg::vic_state_t              state_reg;
    logic [INTERNAL_SOURCES-1:0][7:0] ctrl_reg;
    logic [INTERNAL_SOURCES-1:0]      ctrl_hit;
    logic [7:0]                       ctrl_rd;
    logic                             window;

    always_comb begin
        ctrl_rd = 8'd0;
        for (int k = 0; k < INTERNAL_SOURCES; k++) begin
            ctrl_hit[k] = (item.offset == vic_pkg::OFF_CTRL_BASE + 10'(k));
            if (ctrl_hit[k]) begin
                ctrl_rd = ctrl_rd | ctrl_reg[k];
            end
        end
    end

    assign window = vic_pkg::in_window(item.offset);

    always_comb begin
        state_next = state_reg;
        ctrl_next  = ctrl_reg;
        read_data  = 32'd0;
        status     = vic_pkg::ST_OK;
        unique case (item.op)
            vic_pkg::OP_READ: begin
                if (window) begin
                    status = vic_pkg::ST_WINDOW;
                end else begin
                    unique case (item.offset)
                        vic_pkg::OFF_RESET_STATUS: read_data = 32'(state_reg.reset_status);
                        vic_pkg::OFF_WDOG_VECTOR:  read_data = 32'(state_reg.watchdog_vector);
                        vic_pkg::OFF_PIN_ASSIGN:   read_data = 32'(state_reg.pin_assignment);
                        vic_pkg::OFF_PENDING:      read_data = 32'(state_reg.pending_bits);
                        vic_pkg::OFF_MASK:         read_data = 32'(state_reg.mask_bits);
                        vic_pkg::OFF_AUTOVEC_EN:
                            read_data = 32'(state_reg.autovector_enables);
                        vic_pkg::OFF_SERIAL0_VEC:
                            read_data = 32'(state_reg.serial_vectors[0]);
                        vic_pkg::OFF_SERIAL1_VEC:
                            read_data = 32'(state_reg.serial_vectors[1]);
                        default: begin
                            if (|ctrl_hit) begin
                                read_data = 32'(ctrl_rd);
                            end else begin
                                status = vic_pkg::ST_BAD;
                            end
                        end
                    endcase
                end
            end
            vic_pkg::OP_WRITE: begin
                if (window) begin
                    status = vic_pkg::ST_WINDOW;
                end else begin
                    unique case (item.offset)
                        vic_pkg::OFF_RESET_STATUS:
                            // write one to clear
                            state_next.reset_status =
                                state_reg.reset_status & ~item.write_data[7:0];
                        vic_pkg::OFF_WDOG_VECTOR:
                            state_next.watchdog_vector = item.write_data[7:0];
                        vic_pkg::OFF_PIN_ASSIGN:
                            state_next.pin_assignment = item.write_data[15:0];
                        vic_pkg::OFF_MASK:
                            state_next.mask_bits = item.write_data[vic_pkg::LINE_BITS-1:0];
                        vic_pkg::OFF_AUTOVEC_EN:
                            state_next.autovector_enables = item.write_data[7:0];
                        vic_pkg::OFF_SERIAL0_VEC:
                            state_next.serial_vectors[0] = item.write_data[7:0];
                        vic_pkg::OFF_SERIAL1_VEC:
                            state_next.serial_vectors[1] = item.write_data[7:0];
                        vic_pkg::OFF_WDOG_SERVICE, vic_pkg::OFF_PORT0_A, vic_pkg::OFF_PORT0_B,
                        vic_pkg::OFF_PORT1_A, vic_pkg::OFF_PORT1_B: begin
                            // accepted, no effect
                        end
                        default: begin
                            if (|ctrl_hit) begin
                                for (int k = 0; k < INTERNAL_SOURCES; k++) begin
                                    if (ctrl_hit[k]) begin
                                        ctrl_next[k] = item.write_data[7:0];
                                    end
                                end
                            end else begin
                                status = vic_pkg::ST_BAD;
                            end
                        end
                    endcase
                end
            end
            vic_pkg::OP_LINE: begin
                if (item.irq_line >= 5'd1 && item.irq_line <= LAST_LINE) begin
                    state_next.pending_bits[item.irq_line] = item.irq_active;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.reset_status       <= vic_pkg::RESET_STATUS_INIT;
            state_reg.watchdog_vector    <= vic_pkg::WDOG_VECTOR_INIT;
            state_reg.pin_assignment     <= '0;
            state_reg.mask_bits          <= vic_pkg::MASK_INIT;
            state_reg.pending_bits       <= '0;
            state_reg.autovector_enables <= '0;
            state_reg.serial_vectors     <= '0;
            ctrl_reg                     <= '0;
        end else if (fire) begin
            state_reg <= state_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

// ----- src/vic_prio.sv -----
module vic_prio #(
    parameter int INTERNAL_SOURCES = 10
) (
    input  vic_pkg::vic_state_t              state,
    input  logic [INTERNAL_SOURCES-1:0][7:0] ctrl,
    output logic [2:0]                       irq_level,
    output logic [7:0]                       irq_vector
);

    localparam int NUM_LINES = 8 + INTERNAL_SOURCES;
    localparam int LEAVES    = 1 << $clog2(NUM_LINES);

    logic [vic_pkg::LINE_BITS-1:0] active;
    vic_pkg::vic_node_t            node [2*LEAVES-1];

    assign active = state.pending_bits & ~state.mask_bits;

    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j >= 1 && j < 8) begin : g_ext
            assign node[LEAVES-1+j].key    = active[j] ? {3'(j), 3'b011} : 6'd0;
            assign node[LEAVES-1+j].linen  = ~5'(j);
            assign node[LEAVES-1+j].vector = state.autovector_enables[j]
                                           ? vic_pkg::AUTOVECTOR_BASE + 8'(j)
                                           : vic_pkg::FALLBACK_VECTOR;
        end else if (j >= 8 && j < NUM_LINES) begin : g_int
            logic [7:0] own_vector;
            if (j == 8) begin : g_wdog
                assign own_vector = state.watchdog_vector;
            end else if (j == 12) begin : g_ser0
                assign own_vector = state.serial_vectors[0];
            end else if (j == 13) begin : g_ser1
                assign own_vector = state.serial_vectors[1];
            end else begin : g_none
                assign own_vector = vic_pkg::FALLBACK_VECTOR;
            end
            assign node[LEAVES-1+j].key    = active[j] ? {ctrl[j-8][4:0], 1'b0} : 6'd0;
            assign node[LEAVES-1+j].linen  = ~5'(j);
            assign node[LEAVES-1+j].vector = ctrl[j-8][7]
                                           ? vic_pkg::AUTOVECTOR_BASE + {5'd0, ctrl[j-8][4:2]}
                                           : own_vector;
        end else begin : g_unused
            assign node[LEAVES-1+j] = '0;
        end
    end

    // max tree; lower line wins a tie through the inverted line number
    for (genvar i = 0; i < LEAVES - 1; i++) begin : g_tree
        assign node[i] = ({node[2*i+1].key, node[2*i+1].linen} >=
                          {node[2*i+2].key, node[2*i+2].linen}) ? node[2*i+1] : node[2*i+2];
    end

    // a winner at level zero presents nothing
    assign irq_level  = node[0].key[5:3];
    assign irq_vector = (node[0].key[5:3] != 3'd0) ? node[0].vector : 8'd0;

endmodule

// ----- src/vectored_interrupt_controller.sv -----
// channel | dir | ports                       | beat contents
// s_      | in  | s_tvalid s_tready s_tdata    | s_tuser op; s_tdata offset, write_data,
//         |     | s_tuser                     |   irq_line, irq_active
// m_      | out | m_tvalid m_tready m_tdata    | read_data, status, irq_level, irq_vector
//
// one beat in, one beat out; each beat passes the input register, then the result register
// sustained rate is one beat per cycle while m_ is ready; the register update and the priority
// tree sit between the input and result registers
// aresetn clears the pipeline valids and loads the register reset values
// a stalled m_ side holds the result; s_ still takes one beat into the input register
module vectored_interrupt_controller #(
    parameter int INTERNAL_SOURCES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // offset[9:0] write_data[41:10] irq_line[46:42] irq_active[47]
    input  logic [1:0]  s_tuser,  // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // read_data[31:0] status[33:32] irq_level[36:34]
                                  // irq_vector[44:37], zero fill above
);

    logic                             in_valid_reg;
    logic                             in_valid_next;
    vic_pkg::vic_item_t               item_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [44:0]                      out_data_reg;
    logic                             out_free;
    logic                             fire;
    logic                             s_fire;
    vic_pkg::vic_state_t              state_next;
    logic [INTERNAL_SOURCES-1:0][7:0] ctrl_next;
    logic [31:0]                      read_data;
    logic [1:0]                       status;
    logic [2:0]                       irq_level;
    logic [7:0]                       irq_vector;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    vic_regs #(
        .INTERNAL_SOURCES(INTERNAL_SOURCES)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item_reg),
        .state_next (state_next),
        .ctrl_next  (ctrl_next),
        .read_data  (read_data),
        .status     (status)
    );

    vic_prio #(
        .INTERNAL_SOURCES(INTERNAL_SOURCES)
    ) u_prio (
        .state      (state_next),
        .ctrl       (ctrl_next),
        .irq_level  (irq_level),
        .irq_vector (irq_vector)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.op         <= s_tuser;
            item_reg.offset     <= s_tdata[9:0];
            item_reg.write_data <= s_tdata[41:10];
            item_reg.irq_line   <= s_tdata[46:42];
            item_reg.irq_active <= s_tdata[47];
        end
        if (fire) begin
            out_data_reg <= {irq_vector, irq_level, status, read_data};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    a_no_vector_without_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[36:34] == 3'd0) |-> out_data_reg[44:37] == 8'd0)
        else $error("vector presented with level zero");

    a_fail_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[33:32] != vic_pkg::ST_OK) |-> out_data_reg[31:0] == 32'd0)
        else $error("failed access returned data");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg[33:32] != 2'd3)
        else $error("undefined status code");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready && !fire)
        else $error("beat taken while both stages are full and stalled");

endmodule
